@@ hdl/ckg_pkg.sv @@
// shared types, constants and helpers for the color key fill and gradient block
`timescale 1ns / 1ps
package ckg_pkg;

	localparam int MAX_SLOTS = 3;
	localparam int CH_W      = 8;
	localparam int PIX_W     = 3 * CH_W;
	localparam int SQ_W      = 2 * CH_W;
	localparam int DIST_W    = 18;
	localparam int NUM_W     = 17;
	localparam int MATCH_W   = 45;
	localparam int CFG_IDX_W = 3;

	// match word layout
	localparam int MATCH_USE_IMG = 44;
	localparam int MATCH_ALL     = 43;
	localparam int THR_LSB       = 24;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRADIENT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MATCH0   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FILL0    = 3'd5;

	localparam logic [1:0] NO_HIT = 2'd3;
	localparam logic [CH_W-1:0] CH_MAX = 8'd255;

	typedef logic [PIX_W-1:0]   rgb_t;
	typedef logic [CH_W-1:0]    chan_t;
	typedef logic [MATCH_W-1:0] match_t;

	// input word as it travels the first stages
	typedef struct packed {
		rgb_t                  pixel;
		rgb_t [MAX_SLOTS-1:0]  img;
	} pix_word_t;

	typedef struct packed {
		pix_word_t w;
		chan_t     v;
	} s1_word_t;

	typedef struct packed {
		rgb_t       res;
		rgb_t       bg;
		chan_t      v;
		logic [1:0] hit;
	} s2_word_t;

	typedef struct packed {
		logic [2:0][NUM_W-1:0] num;
		rgb_t                  res;
		logic [1:0]            hit;
	} s3_word_t;

	// channel k of a pixel, k = 0 is red
	function automatic chan_t chan(input rgb_t rgb, input int k);
		return rgb[(2 - k) * CH_W +: CH_W];
	endfunction

endpackage

@@ hdl/ckg_dist.sv @@
// stage 1: per-channel squared key distances and brightest channel
`timescale 1ns / 1ps
module ckg_dist import ckg_pkg::*; #(
	parameter int NUM_ENTRIES = 3
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_valid,
	input  pix_word_t                             in_word,
	input  rgb_t                                  key [NUM_ENTRIES],
	output logic                                  valid_s1,
	output s1_word_t                              word_s1,
	output logic [NUM_ENTRIES-1:0][2:0][SQ_W-1:0] sq_s1
);

	logic [NUM_ENTRIES-1:0][2:0][SQ_W-1:0] sq_c;
	chan_t v_c;

	always_comb begin
		chan_t a;
		chan_t b;
		chan_t d;
		for (int e = 0; e < NUM_ENTRIES; e++) begin
			for (int k = 0; k < 3; k++) begin
				a = chan(in_word.pixel, k);
				b = chan(key[e], k);
				d = (a >= b) ? (a - b) : (b - a);
				sq_c[e][k] = SQ_W'(d) * SQ_W'(d);
			end
		end
	end

	always_comb begin
		v_c = '0;
		for (int k = 0; k < 3; k++) begin
			if (chan(in_word.pixel, k) > v_c) begin
				v_c = chan(in_word.pixel, k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			word_s1.w <= in_word;
			word_s1.v <= v_c;
			sq_s1     <= sq_c;
		end
	end

endmodule

@@ hdl/ckg_match.sv @@
// stage 2: threshold compare, first-hit select and fill color pick
`timescale 1ns / 1ps
module ckg_match import ckg_pkg::*; #(
	parameter int NUM_ENTRIES = 3
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_valid,
	input  s1_word_t                              in_word,
	input  logic [NUM_ENTRIES-1:0][2:0][SQ_W-1:0] sq,
	input  match_t                                entry_match [NUM_ENTRIES],
	input  rgb_t                                  entry_fill [NUM_ENTRIES],
	input  logic                                  gradient,
	input  logic [1:0]                            count,
	output logic                                  valid_s2,
	output s2_word_t                              word_s2
);

	rgb_t       color [NUM_ENTRIES];
	logic [NUM_ENTRIES-1:0] hits;
	logic [NUM_ENTRIES-1:0] active;
	rgb_t       res_c;
	logic [1:0] hit_c;

	always_comb begin
		logic [DIST_W-1:0] sq_sum;
		for (int e = 0; e < NUM_ENTRIES; e++) begin
			sq_sum = DIST_W'(sq[e][0]) + DIST_W'(sq[e][1]) + DIST_W'(sq[e][2]);
			hits[e] = entry_match[e][MATCH_ALL] ||
				(sq_sum <= entry_match[e][THR_LSB +: DIST_W]);
			color[e] = entry_match[e][MATCH_USE_IMG] ? in_word.w.img[e] : entry_fill[e];
			// entry 0 is the background in gradient mode
			active[e] = (2'(e) < count) && !(gradient && (e == 0));
		end
	end

	always_comb begin
		logic found;
		found = 1'b0;
		hit_c = NO_HIT;
		res_c = in_word.w.pixel;
		for (int e = 0; e < NUM_ENTRIES; e++) begin
			if (!found && active[e] && hits[e]) begin
				found = 1'b1;
				hit_c = 2'(e);
				res_c = color[e];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			word_s2.res <= res_c;
			word_s2.bg  <= color[0];
			word_s2.v   <= in_word.v;
			word_s2.hit <= hit_c;
		end
	end

endmodule

@@ hdl/ckg_blend.sv @@
// stages 3 and 4: gradient blend products, divide by 255 with rounding, saturate
`timescale 1ns / 1ps
module ckg_blend import ckg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en_s3,
	input  logic       en_s4,
	input  logic       in_valid,
	input  s2_word_t   in_word,
	input  logic       gradient,
	input  logic       multi,
	output logic       valid_s3,
	output logic       valid_s4,
	output rgb_t       color_s4,
	output logic [1:0] hit_s4
);

	s3_word_t word_s3;
	logic [2:0][NUM_W-1:0] num_c;
	rgb_t blend_c;

	// numerator per channel, rounding offset folded in
	always_comb begin
		chan_t a;
		chan_t b;
		logic [SQ_W-1:0] pa;
		logic [SQ_W-1:0] pb;
		for (int k = 0; k < 3; k++) begin
			a  = chan(in_word.res, k);
			b  = chan(in_word.bg, k);
			pa = SQ_W'(a) * SQ_W'(multi ? in_word.v : CH_MAX);
			pb = SQ_W'(b) * SQ_W'(CH_MAX - in_word.v);
			num_c[k] = NUM_W'(pa) + NUM_W'(pb) + NUM_W'(127);
		end
	end

	// x / 255 as (x + x/256 + 1) / 256, exact up to a quotient of 256,
	// larger quotients may come out one low but still saturate
	always_comb begin
		logic [NUM_W-1:0] x;
		logic [NUM_W-1:0] t;
		logic [8:0] q;
		for (int k = 0; k < 3; k++) begin
			x = word_s3.num[k];
			t = x + (x >> 8) + NUM_W'(1);
			q = t[16:8];
			blend_c[(2 - k) * CH_W +: CH_W] = (q > 9'd255) ? CH_MAX : q[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s3) begin
				valid_s3 <= in_valid;
			end
			if (en_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && in_valid) begin
			word_s3.num <= num_c;
			word_s3.res <= in_word.res;
			word_s3.hit <= in_word.hit;
		end
		if (en_s4 && valid_s3) begin
			color_s4 <= gradient ? blend_c : word_s3.res;
			hit_s4   <= word_s3.hit;
		end
	end

endmodule

@@ hdl/color_key_fill_and_gradient.sv @@
// top level: color key fill and gradient blend pipeline with config registers
//
// channel   dir   width  contents (lowest bits first)
// s_*       in    96     pixel_color, image_pixel_0, image_pixel_1, image_pixel_2
// m_*       out   32     out_color, hit_entry, zero pad
// cfg_*     in    45     register write, index 0..7
//
// four register stages: squares and max channel, threshold and select,
// blend products, divide and saturate; one word enters per cycle while s_tready is high
// every stage takes a new word each cycle, so one pixel per clock while m_tready is high
// arst_n clears valid bits and config registers (entry_count resets to 1)
// each stage holds while the next is full and stalled; bubbles are squeezed out
// config is expected to change only while the pipeline is empty
`timescale 1ns / 1ps
module color_key_fill_and_gradient import ckg_pkg::*; #(
	parameter int NUM_ENTRIES = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// pixel_color [23:0], image_pixel_0 [47:24], image_pixel_1 [71:48], image_pixel_2 [95:72]
	input  logic [95:0]          s_tdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// out_color [23:0], hit_entry [25:24], zero [31:26]
	output logic [31:0]          m_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MATCH_W-1:0]   cfg_data
);

	// configuration registers
	logic       gradient_q;
	logic [1:0] entry_count_q;
	match_t     entry_match_q [NUM_ENTRIES];
	rgb_t       entry_fill_q  [NUM_ENTRIES];

	logic [1:0] count_c;
	rgb_t       key_c [NUM_ENTRIES];

	pix_word_t  in_word;
	logic       valid_s1, valid_s2, valid_s3, valid_s4;
	logic       adv1, adv2, adv3, adv4;
	s1_word_t   word_s1;
	s2_word_t   word_s2;
	logic [NUM_ENTRIES-1:0][2:0][SQ_W-1:0] sq_s1;
	rgb_t       color_s4;
	logic [1:0] hit_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gradient_q    <= 1'b0;
			entry_count_q <= 2'd1;
			for (int e = 0; e < NUM_ENTRIES; e++) begin
				entry_match_q[e] <= '0;
				entry_fill_q[e]  <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == REG_GRADIENT) begin
				gradient_q <= cfg_data[0];
			end
			if (cfg_index == REG_COUNT) begin
				entry_count_q <= cfg_data[1:0];
			end
			// writes to entries past NUM_ENTRIES are dropped, they are never read
			for (int e = 0; e < NUM_ENTRIES; e++) begin
				if (cfg_index == REG_MATCH0 + CFG_IDX_W'(e)) begin
					entry_match_q[e] <= cfg_data;
				end
				if (cfg_index == REG_FILL0 + CFG_IDX_W'(e)) begin
					entry_fill_q[e] <= cfg_data[PIX_W-1:0];
				end
			end
		end
	end

	// entry count clamped to 1..NUM_ENTRIES, zero acts as one
	always_comb begin
		priority if (entry_count_q == 2'd0) begin
			count_c = 2'd1;
		end else if (entry_count_q > 2'(NUM_ENTRIES)) begin
			count_c = 2'(NUM_ENTRIES);
		end else begin
			count_c = entry_count_q;
		end
	end

	always_comb begin
		for (int e = 0; e < NUM_ENTRIES; e++) begin
			key_c[e] = entry_match_q[e][PIX_W-1:0];
		end
	end

	// stall chain: a stage moves when it is empty or the next one moves
	assign adv4     = !valid_s4 || m_tready;
	assign adv3     = !valid_s3 || adv4;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign s_tready = adv1;

	assign in_word.pixel  = s_tdata[23:0];
	assign in_word.img[0] = s_tdata[47:24];
	assign in_word.img[1] = s_tdata[71:48];
	assign in_word.img[2] = s_tdata[95:72];

	ckg_dist #(
		.NUM_ENTRIES (NUM_ENTRIES)
	) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv1),
		.in_valid (s_tvalid),
		.in_word  (in_word),
		.key      (key_c),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1),
		.sq_s1    (sq_s1)
	);

	ckg_match #(
		.NUM_ENTRIES (NUM_ENTRIES)
	) u_match (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv2),
		.in_valid    (valid_s1),
		.in_word     (word_s1),
		.sq          (sq_s1),
		.entry_match (entry_match_q),
		.entry_fill  (entry_fill_q),
		.gradient    (gradient_q),
		.count       (count_c),
		.valid_s2    (valid_s2),
		.word_s2     (word_s2)
	);

	ckg_blend u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.en_s3    (adv3),
		.en_s4    (adv4),
		.in_valid (valid_s2),
		.in_word  (word_s2),
		.gradient (gradient_q),
		.multi    (count_c > 2'd1),
		.valid_s3 (valid_s3),
		.valid_s4 (valid_s4),
		.color_s4 (color_s4),
		.hit_s4   (hit_s4)
	);

	assign m_tvalid = valid_s4;
	assign m_tdata  = {6'd0, hit_s4, color_s4};

	// an empty output register never blocks the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output stage");

	// a word accepted with no downstream stall passes the stage registers in order and reaches the output
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
		else $error("accepted word did not reach the output");

	// a stalled first stage keeps its word
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv2) |=> valid_s1)
		else $error("stage 1 word lost during stall");

endmodule
